@@ design/ede_pkg.sv @@
// ----------------------------------------------------------------------------
// Edit distance engine package
// Shared sizes, command and status codes, and the link between array cells.
// ----------------------------------------------------------------------------
package ede_pkg;

    localparam int MAX_LEN = 64;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int SYM_W   = 8;
    localparam int DIST_W  = 7;
    localparam int STAT_W  = 2;
    localparam int DIST_MAX = (1 << DIST_W) - 1;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_FIRST  = 2'd1,
        CMD_SECOND = 2'd2,
        CMD_FINISH = 2'd3
    } cmd_t;

    localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
    localparam logic [STAT_W-1:0] ST_FIRST_LONG = 2'd1;
    localparam logic [STAT_W-1:0] ST_SECOND_LONG = 2'd2;
    localparam logic [STAT_W-1:0] ST_ORDER      = 2'd3;

    typedef struct packed {
        logic             valid;
        logic [SYM_W-1:0] sym;
        logic [LEN_W-1:0] left;
        logic [LEN_W-1:0] diag;
    } link_t;

endpackage

@@ design/ede_cell.sv @@
// ----------------------------------------------------------------------------
// Edit distance array cell
// Holds one first-string symbol and one distance entry, updates the entry
// when a second-string symbol passes, and hands the symbol on to the right.
// ----------------------------------------------------------------------------
module ede_cell (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       load_en,
    input  logic [ede_pkg::SYM_W-1:0]  load_sym,
    input  logic [ede_pkg::LEN_W-1:0]  load_row,
    input  ede_pkg::link_t             link_in,
    output ede_pkg::link_t             link_out,
    output logic [ede_pkg::LEN_W-1:0]  row_out
);
    import ede_pkg::*;

    logic [SYM_W-1:0] char_reg;
    logic [LEN_W-1:0] row_reg;
    logic [LEN_W-1:0] row_next;
    logic [LEN_W-1:0] min_lr;
    logic [LEN_W-1:0] min_all;
    link_t            link_reg;

    always_comb begin
        min_lr  = (link_in.left < row_reg) ? link_in.left : row_reg;
        min_all = (min_lr < link_in.diag) ? min_lr : link_in.diag;
        if (link_in.sym == char_reg) begin
            row_next = link_in.diag;
        end else begin
            row_next = min_all + LEN_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            char_reg <= load_sym;
            row_reg  <= load_row;
        end else if (link_in.valid) begin
            row_reg <= row_next;
        end
        link_reg.sym  <= link_in.sym;
        link_reg.left <= row_next;
        link_reg.diag <= row_reg;
        if (!aresetn) begin
            link_reg.valid <= 1'b0;
        end else begin
            link_reg.valid <= link_in.valid;
        end
    end

    assign link_out = link_reg;
    assign row_out  = row_reg;

endmodule

@@ design/edit_distance_engine.sv @@
// ----------------------------------------------------------------------------
// Edit distance engine
// Levenshtein distance between two byte strings on a systolic row of cells.
// ----------------------------------------------------------------------------
//  Channel  | Ports                          | Carries
//  ---------+--------------------------------+-------------------------------
//  input    | s_valid s_ready s_command s_symbol | commands and string symbols
//  result   | m_valid m_ready m_distance m_status | distance and status on finish
//
// A second-string symbol is accepted in any cycle and travels one cell per
// cycle through the MAX_LEN cells, so symbols stream back to back.
// Start, first-string and finish transactions wait until the last symbol has
// passed the final cell.
// A finish also waits while an earlier result is held and not taken.
// Reset is synchronous and clears lengths, flags, the first entry and valids.
module edit_distance_engine (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_command,
    input  logic [ede_pkg::SYM_W-1:0]    s_symbol,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [ede_pkg::DIST_W-1:0]   m_distance,
    output logic [ede_pkg::STAT_W-1:0]   m_status
);
    import ede_pkg::*;

    logic [LEN_W-1:0]  first_len_reg;
    logic [LEN_W-1:0]  second_len_reg;
    logic              second_begun_reg;
    logic [STAT_W-1:0] err_reg;
    logic [LEN_W-1:0]  row0_reg;
    logic [IDX_W-1:0]  wave_cnt_reg;
    logic              m_valid_reg;
    logic [DIST_W-1:0] m_distance_reg;
    logic [STAT_W-1:0] m_status_reg;

    cmd_t              cmd;
    logic              accept;
    logic              busy;
    logic              first_ok;
    logic              launch;
    logic [LEN_W-1:0]  fin_row;
    link_t             head_link;
    link_t             links [0:MAX_LEN];
    logic [LEN_W-1:0]  rows [0:MAX_LEN];

    assign cmd    = cmd_t'(s_command);
    assign busy   = (wave_cnt_reg != '0);
    assign accept = s_valid && s_ready;

    always_comb begin
        case (cmd)
            CMD_SECOND: s_ready = 1'b1;
            CMD_FINISH: s_ready = !busy && (!m_valid_reg || m_ready);
            default:    s_ready = !busy;
        endcase
    end

    assign first_ok = accept && (cmd == CMD_FIRST) && !second_begun_reg
                      && (first_len_reg < LEN_W'(MAX_LEN));
    assign launch   = accept && (cmd == CMD_SECOND)
                      && (second_len_reg < LEN_W'(MAX_LEN));

    assign head_link.valid = launch;
    assign head_link.sym   = s_symbol;
    assign head_link.left  = second_len_reg + LEN_W'(1);
    assign head_link.diag  = row0_reg;
    assign links[0] = head_link;
    assign rows[0]  = row0_reg;

    for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
        ede_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .load_en  (first_ok && (first_len_reg[IDX_W-1:0] == IDX_W'(k))),
            .load_sym (s_symbol),
            .load_row (first_len_reg + LEN_W'(1)),
            .link_in  (links[k]),
            .link_out (links[k+1]),
            .row_out  (rows[k+1])
        );
    end

    assign fin_row = rows[first_len_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_len_reg    <= '0;
            second_len_reg   <= '0;
            second_begun_reg <= 1'b0;
            err_reg          <= ST_OK;
            row0_reg         <= '0;
            wave_cnt_reg     <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (launch) begin
                wave_cnt_reg <= IDX_W'(MAX_LEN - 1);
            end else if (busy) begin
                wave_cnt_reg <= wave_cnt_reg - IDX_W'(1);
            end
            if (accept && (cmd == CMD_FINISH)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (accept) begin
                case (cmd)
                    CMD_START: begin
                        first_len_reg    <= '0;
                        second_len_reg   <= '0;
                        second_begun_reg <= 1'b0;
                        err_reg          <= ST_OK;
                        row0_reg         <= '0;
                    end
                    CMD_FIRST: begin
                        if (second_begun_reg) begin
                            if (err_reg == ST_OK) begin
                                err_reg <= ST_ORDER;
                            end
                        end else if (!first_ok) begin
                            if (err_reg == ST_OK) begin
                                err_reg <= ST_FIRST_LONG;
                            end
                        end else begin
                            first_len_reg <= first_len_reg + LEN_W'(1);
                        end
                    end
                    CMD_SECOND: begin
                        second_begun_reg <= 1'b1;
                        if (launch) begin
                            second_len_reg <= second_len_reg + LEN_W'(1);
                            row0_reg       <= second_len_reg + LEN_W'(1);
                        end else if (err_reg == ST_OK) begin
                            err_reg <= ST_SECOND_LONG;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        if (accept && (cmd == CMD_FINISH)) begin
            if (int'(fin_row) > DIST_MAX) begin
                m_distance_reg <= DIST_W'(DIST_MAX);
            end else begin
                m_distance_reg <= DIST_W'(fin_row);
            end
            m_status_reg <= err_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_distance = m_distance_reg;
    assign m_status   = m_status_reg;

    a_no_load_in_wave: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !(accept && (cmd != CMD_SECOND)))
        else $error("Non-symbol transaction accepted while a wave is in flight.");

    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(accept && (cmd == CMD_FINISH)))
        else $error("Result raised without a finish transaction.");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (first_len_reg <= LEN_W'(MAX_LEN)) && (second_len_reg <= LEN_W'(MAX_LEN)))
        else $error("String length exceeds the maximum.");

    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        ((err_reg != ST_OK) && !(accept && (cmd == CMD_START)))
        |=> (err_reg == $past(err_reg)))
        else $error("Error status changed without a start.");

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// Edit distance engine testbench
// Drives start, string and finish transactions into the engine and checks
// every finish result against a cycle-free Levenshtein predictor or a typed
// row's answer.  A short table of directed transactions covers empty
// strings, full and overlong strings, order errors and repeated finishes,
// and random pairs follow with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    import ede_pkg::*;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [STAT_W-1:0] stat;
    } answer_t;

    typedef struct packed {
        cmd_t             cmd;
        logic [SYM_W-1:0] sym;
        logic [6:0]       reps;
        logic             typed;
        answer_t          ans;
    } row_t;

    localparam int DIR_ROWS     = 25;
    localparam int RANDOM_ITEMS = 1650;

    logic               aclk;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    logic [1:0]         s_command = CMD_START;
    logic [SYM_W-1:0]   s_symbol  = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    logic [DIST_W-1:0]  m_distance;
    logic [STAT_W-1:0]  m_status;

    edit_distance_engine dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_command  (s_command),
        .s_symbol   (s_symbol),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_distance (m_distance),
        .m_status   (m_status)
    );

    // Rows with the typed flag carry an answer that is obvious from the strings.
    row_t dir_table [DIR_ROWS] = '{
        '{CMD_START,  8'hFF, 7'd1,  1'b0, '{7'd0,  ST_OK}},
        '{CMD_FINISH, 8'h00, 7'd1,  1'b1, '{7'd0,  ST_OK}},
        '{CMD_FIRST,  8'h00, 7'd1,  1'b0, '{7'd0,  ST_OK}},
        '{CMD_FIRST,  8'hFF, 7'd1,  1'b0, '{7'd0,  ST_OK}},
        '{CMD_SECOND, 8'hFF, 7'd1,  1'b0, '{7'd0,  ST_OK}},
        '{CMD_SECOND, 8'h00, 7'd1,  1'b0, '{7'd0,  ST_OK}},
        '{CMD_FINISH, 8'hA5, 7'd1,  1'b0, '{7'd0,  ST_OK}},
        '{CMD_FINISH, 8'h5A, 7'd1,  1'b0, '{7'd0,  ST_OK}},
        '{CMD_FIRST,  8'h55, 7'd1,  1'b0, '{7'd0,  ST_OK}},
        '{CMD_SECOND, 8'h80, 7'd1,  1'b0, '{7'd0,  ST_OK}},
        '{CMD_FINISH, 8'h00, 7'd1,  1'b0, '{7'd0,  ST_OK}},
        '{CMD_START,  8'h00, 7'd1,  1'b0, '{7'd0,  ST_OK}},
        '{CMD_SECOND, 8'hAA, 7'd1,  1'b0, '{7'd0,  ST_OK}},
        '{CMD_FINISH, 8'hFF, 7'd1,  1'b1, '{7'd1,  ST_OK}},
        '{CMD_START,  8'h00, 7'd1,  1'b0, '{7'd0,  ST_OK}},
        '{CMD_FIRST,  8'h00, 7'd65, 1'b0, '{7'd0,  ST_OK}},
        '{CMD_FINISH, 8'h00, 7'd1,  1'b1, '{7'd64, ST_FIRST_LONG}},
        '{CMD_SECOND, 8'h00, 7'd65, 1'b0, '{7'd0,  ST_OK}},
        '{CMD_FINISH, 8'h00, 7'd1,  1'b1, '{7'd0,  ST_FIRST_LONG}},
        '{CMD_START,  8'h00, 7'd1,  1'b0, '{7'd0,  ST_OK}},
        '{CMD_SECOND, 8'h10, 7'd65, 1'b0, '{7'd0,  ST_OK}},
        '{CMD_FINISH, 8'h00, 7'd1,  1'b1, '{7'd64, ST_SECOND_LONG}},
        '{CMD_FIRST,  8'h01, 7'd1,  1'b0, '{7'd0,  ST_OK}},
        '{CMD_FINISH, 8'h00, 7'd1,  1'b1, '{7'd64, ST_SECOND_LONG}},
        '{CMD_START,  8'h00, 7'd1,  1'b0, '{7'd0,  ST_OK}}
    };

    answer_t          awaited_answers[$];
    int unsigned      items_sent   = 0;
    int unsigned      results_seen = 0;
    int unsigned      mismatches   = 0;
    bit               tx_quiet     = 1'b0;
    bit               rx_quiet     = 1'b0;

    logic [SYM_W-1:0] first_syms [MAX_LEN];
    int unsigned      dist_row [MAX_LEN+1];
    int unsigned      first_len      = 0;
    int unsigned      second_len     = 0;
    bit               second_started = 1'b0;
    logic [STAT_W-1:0] err_code      = ST_OK;

    logic [SYM_W-1:0] alphabet [4];
    bit               wide_alphabet;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #6000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("%0t: %s", $time, msg);
    endtask

    function automatic void note_error(input logic [STAT_W-1:0] code);
        if (err_code == ST_OK) begin
            err_code = code;
        end
    endfunction

    function automatic void edit_distance_step(input cmd_t cmd, input logic [SYM_W-1:0] sym,
                                               output bit has_answer, output answer_t ans);
        int unsigned diag;
        int unsigned above;
        int unsigned best;
        has_answer = 1'b0;
        ans = '0;
        case (cmd)
            CMD_START: begin
                first_len = 0;
                second_len = 0;
                second_started = 1'b0;
                err_code = ST_OK;
                dist_row[0] = 0;
            end
            CMD_FIRST: begin
                if (second_started) begin
                    note_error(ST_ORDER);
                end else if (first_len >= MAX_LEN) begin
                    note_error(ST_FIRST_LONG);
                end else begin
                    first_syms[first_len] = sym;
                    first_len++;
                    dist_row[first_len] = first_len;
                end
            end
            CMD_SECOND: begin
                second_started = 1'b1;
                if (second_len >= MAX_LEN) begin
                    note_error(ST_SECOND_LONG);
                end else begin
                    diag = dist_row[0];
                    dist_row[0] = second_len + 1;
                    for (int i = 1; i <= first_len; i++) begin
                        above = dist_row[i];
                        if (first_syms[i-1] == sym) begin
                            dist_row[i] = diag;
                        end else begin
                            best = dist_row[i-1];
                            if (above < best) best = above;
                            if (diag < best) best = diag;
                            dist_row[i] = best + 1;
                        end
                        diag = above;
                    end
                    second_len++;
                end
            end
            default: begin
                has_answer = 1'b1;
                best = dist_row[first_len];
                ans.distance = (best > DIST_MAX) ? DIST_W'(DIST_MAX) : DIST_W'(best);
                ans.stat = err_code;
            end
        endcase
    endfunction

    task automatic offer(input cmd_t cmd, input logic [SYM_W-1:0] sym,
                         input bit typed, input answer_t typed_ans);
        int unsigned gap;
        bit has_answer;
        answer_t ans;
        gap = tx_quiet ? 0 : $urandom_range(0, 9);
        if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
        if (gap != 0) begin
            @(negedge aclk) s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_symbol  <= sym;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        edit_distance_step(cmd, sym, has_answer, ans);
        if (has_answer) awaited_answers = {awaited_answers, typed ? typed_ans : ans};
    endtask

    function automatic int unsigned draw_length();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 85) return $urandom_range(0, 8);
        if (pick < 95) return $urandom_range(9, 40);
        return $urandom_range(MAX_LEN - 4, MAX_LEN + 2);
    endfunction

    function automatic logic [SYM_W-1:0] string_symbol();
        if (wide_alphabet) return SYM_W'($urandom);
        return alphabet[$urandom_range(0, 3)];
    endfunction

    // Result channel: random stalls, two long holds that back the engine up.
    initial begin : result_sink
        int unsigned rx_wait;
        answer_t want;
        while (aresetn !== 1'b1) @(posedge aclk);
        @(negedge aclk) m_ready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                results_seen++;
                if (awaited_answers.size() == 0) begin
                    report_mismatch($sformatf("result with no finish pending: distance %0d status %0d",
                                              m_distance, m_status));
                end else begin
                    want = awaited_answers.pop_front();
                    if (m_distance !== want.distance) begin
                        report_mismatch($sformatf("distance %0d, expected %0d (result %0d)",
                                                  m_distance, want.distance, results_seen));
                    end
                    if (m_status !== want.stat) begin
                        report_mismatch($sformatf("status %0d, expected %0d (result %0d)",
                                                  m_status, want.stat, results_seen));
                    end
                end
                if (results_seen == 15 || results_seen == 90) begin
                    rx_wait = 400;
                end else begin
                    rx_wait = rx_quiet ? 0 : $urandom_range(0, 9);
                end
                if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
                if (rx_wait != 0) begin
                    @(negedge aclk) m_ready <= 1'b0;
                    repeat (rx_wait - 1) @(negedge aclk);
                    @(negedge aclk) m_ready <= 1'b1;
                end
            end
        end
    end

    initial begin : stimulus
        int unsigned dir_items;
        int unsigned first_n;
        int unsigned second_n;
        int unsigned pick;
        bit drained_once;
        drained_once = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            for (int k = 0; k < dir_table[r].reps; k++) begin
                offer(dir_table[r].cmd, dir_table[r].sym + SYM_W'(k),
                      dir_table[r].typed, dir_table[r].ans);
            end
        end
        dir_items = items_sent;

        while (items_sent - dir_items < RANDOM_ITEMS) begin
            if (!drained_once && items_sent - dir_items >= RANDOM_ITEMS / 2) begin
                drained_once = 1'b1;
                @(negedge aclk) s_valid <= 1'b0;
                while (awaited_answers.size() != 0) @(posedge aclk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                repeat ($urandom_range(1, 5)) begin
                    offer(cmd_t'($urandom_range(0, 3)), SYM_W'($urandom), 1'b0, '0);
                end
            end else begin
                wide_alphabet = ($urandom_range(0, 3) == 0);
                foreach (alphabet[a]) alphabet[a] = SYM_W'($urandom);
                first_n  = draw_length();
                second_n = draw_length();
                offer(CMD_START, SYM_W'($urandom), 1'b0, '0);
                repeat (first_n) offer(CMD_FIRST, string_symbol(), 1'b0, '0);
                repeat (second_n) offer(CMD_SECOND, string_symbol(), 1'b0, '0);
                offer(CMD_FINISH, SYM_W'($urandom), 1'b0, '0);
                pick = $urandom_range(0, 9);
                if (pick < 3) begin
                    repeat ($urandom_range(1, 4)) offer(CMD_SECOND, string_symbol(), 1'b0, '0);
                    offer(CMD_FINISH, SYM_W'($urandom), 1'b0, '0);
                end else if (pick == 3) begin
                    offer(CMD_FIRST, string_symbol(), 1'b0, '0);
                    offer(CMD_FINISH, SYM_W'($urandom), 1'b0, '0);
                end else if (pick == 4) begin
                    offer(CMD_FINISH, SYM_W'($urandom), 1'b0, '0);
                end
            end
        end

        @(negedge aclk) s_valid <= 1'b0;
        while (awaited_answers.size() != 0) @(posedge aclk);
        repeat (MAX_LEN + 20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
